FILE: rtl/core/twg_pkg.sv
// twg_pkg: shared types, codes and the sine table for the table waveform generator.
// Stand-alone; imported by twg_ctrl, twg_scale and table_waveform_generator.
`timescale 1ns / 1ps

package twg_pkg;

  // Table sizes. Both must be powers of two, USER_POINTS <= TABLE_POINTS.
  localparam int TABLE_POINTS = 256;
  localparam int USER_POINTS  = 8;
  localparam int PHASE_W      = $clog2(TABLE_POINTS);
  localparam int USER_W       = $clog2(USER_POINTS);

  localparam logic [7:0] AMP_MAX   = 8'd255;
  localparam logic [7:0] AMP_MIN   = 8'd16;
  localparam logic [7:0] AMP_DELTA = 8'd16;
  localparam logic [5:0] STEP_MIN  = 6'd1;
  localparam logic [5:0] STEP_MAX  = 6'd50;

  // Request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_BUTTON = 2'd1;
  localparam logic [1:0] REQ_BYTE   = 2'd2;

  // Button bit positions
  localparam int BTN_AMP_UP    = 0;
  localparam int BTN_AMP_DOWN  = 1;
  localparam int BTN_STEP_DOWN = 2;
  localparam int BTN_STEP_UP   = 3;
  localparam int BTN_NEXT_WAVE = 4;

  typedef enum logic [2:0] {
    KIND_SINE,
    KIND_TRIANGLE,
    KIND_SAWTOOTH,
    KIND_SQUARE,
    KIND_USER
  } wave_kind_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] buttons;
    logic [7:0] rx_byte;
  } twg_in_t;

  typedef struct packed {
    logic [7:0] dac_code;
    logic [2:0] wave_kind;
    logic       amp_above_half;
  } twg_out_t;

  // Unscaled sample on its way to the scaler
  typedef struct packed {
    logic       valid;
    logic [7:0] sample;
    logic [7:0] amp;
    logic [2:0] kind;
  } twg_stage_t;

  // Sine table, built at elaboration in Q30 fixed point
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259422;  // 3.14159265 in Q30

  typedef logic [7:0] sine_rom_t [TABLE_POINTS];

  // sin(x), x in 0..pi/2, Taylor series to x^21, products truncated
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd342; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd420; sum = sum + longint'(term);
    if (sum < 0) sum = 0;
    if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
    return 64'(sum);
  endfunction

  function automatic logic [7:0] sine_point(input int unsigned i);
    logic [63:0] n;
    logic [63:0] ii;
    logic [63:0] mag;
    logic [63:0] th;
    logic [63:0] base;
    logic [63:0] scaled;
    logic        neg;
    n   = 64'(TABLE_POINTS);
    ii  = 64'(i);
    neg = 1'b0;
    mag = '0;
    th  = '0;
    if (ii == 0 || 2 * ii == n) begin
      mag = '0;
    end else if (4 * ii == n) begin
      mag = Q30_ONE;
    end else if (4 * ii == 3 * n) begin
      mag = Q30_ONE;
      neg = 1'b1;
    end else begin
      th = (64'd2 * PI_Q30 * ii) / 64'(TABLE_POINTS);
      if (2 * ii > n) begin
        neg = 1'b1;
        th  = (th > PI_Q30) ? th - PI_Q30 : 64'd0;
      end
      if (th > PI_Q30 / 2) th = (th < PI_Q30) ? PI_Q30 - th : 64'd0;
      mag = sine_q30(th);
    end
    base   = neg ? Q30_ONE - mag : Q30_ONE + mag;
    scaled = (base * 64'd255) >> 31;
    return scaled[7:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < TABLE_POINTS; i++) rom[i] = sine_point(i);
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: rtl/core/twg_ctrl.sv
// twg_ctrl: generator state (wave, amplitude, step, phase, user points),
// item decode and the unscaled sample register. Depends on twg_pkg.
`timescale 1ns / 1ps

module twg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  twg_pkg::twg_in_t    item,
  input  logic                s2_free,
  output logic                item_take,
  output twg_pkg::twg_stage_t stage
);
  import twg_pkg::*;

  localparam int TRI_W = PHASE_W + 9;
  localparam int SAW_W = PHASE_W + 8;

  wave_kind_t         wave_select, wave_select_next;
  logic [7:0]         amp_level, amp_level_next;
  logic [5:0]         phase_step, phase_step_next;
  logic [PHASE_W-1:0] phase_index, phase_index_next;
  logic [USER_W-1:0]  load_count, load_count_next;
  logic [7:0]         user_points [USER_POINTS];

  logic               is_tick, is_button, is_byte, s1_free, user_wr;
  logic [PHASE_W-1:0] ph_low;
  logic [TRI_W-1:0]   tri_prod;
  logic [SAW_W-1:0]   saw_prod;
  logic [7:0]         tri_val, sample;
  logic [8:0]         amp_sum;
  logic [7:0]         amp_a, amp_b;
  logic [5:0]         step_a, step_b;

  assign is_tick   = item.req_type == REQ_TICK;
  assign is_button = item.req_type == REQ_BUTTON;
  assign is_byte   = item.req_type == REQ_BYTE;
  assign s1_free   = !stage.valid || s2_free;
  assign item_take = item_valid && (!is_tick || s1_free);
  assign user_wr   = item_take && is_byte && wave_select == KIND_USER;

  // shape lookup from the current phase
  assign ph_low   = {1'b0, phase_index[PHASE_W-2:0]};
  assign tri_prod = TRI_W'(ph_low) * TRI_W'(510);
  assign saw_prod = SAW_W'(phase_index) * SAW_W'(255);
  assign tri_val  = tri_prod[PHASE_W +: 8];

  always_comb begin
    case (wave_select)
      KIND_SINE:     sample = SINE_ROM[phase_index];
      KIND_TRIANGLE: sample = phase_index[PHASE_W-1] ? AMP_MAX - tri_val : tri_val;
      KIND_SAWTOOTH: sample = saw_prod[PHASE_W +: 8];
      KIND_SQUARE:   sample = phase_index[PHASE_W-1] ? 8'd0 : AMP_MAX;
      KIND_USER:     sample = user_points[phase_index[PHASE_W-1 -: USER_W]];
      default:       sample = 8'd0;
    endcase
  end

  // button chain: next wave, amp up, amp down, step up, step down
  assign amp_sum = {1'b0, amp_level} + {1'b0, AMP_DELTA};
  assign amp_a   = !item.buttons[BTN_AMP_UP] ? amp_level :
                   (amp_sum[8] ? AMP_MAX : amp_sum[7:0]);
  assign amp_b   = !item.buttons[BTN_AMP_DOWN] ? amp_a :
                   (amp_a < AMP_MIN + AMP_DELTA ? AMP_MIN : amp_a - AMP_DELTA);
  assign step_a  = !item.buttons[BTN_STEP_UP] ? phase_step :
                   (phase_step >= STEP_MAX ? STEP_MAX : phase_step + 6'd1);
  assign step_b  = !item.buttons[BTN_STEP_DOWN] ? step_a :
                   (step_a <= STEP_MIN ? STEP_MIN : step_a - 6'd1);

  always_comb begin
    wave_select_next = wave_select;
    amp_level_next   = amp_level;
    phase_step_next  = phase_step;
    phase_index_next = phase_index;
    load_count_next  = load_count;
    if (item_take) begin
      if (is_tick) begin
        phase_index_next = phase_index + PHASE_W'(phase_step);
      end else if (is_button) begin
        amp_level_next  = amp_b;
        phase_step_next = step_b;
        if (item.buttons[BTN_NEXT_WAVE]) begin
          wave_select_next = (wave_select == KIND_USER) ? KIND_SINE :
                             wave_kind_t'(3'(wave_select + 3'd1));
          phase_index_next = '0;
          if (wave_select_next == KIND_USER) load_count_next = '0;
        end
      end else if (user_wr) begin
        load_count_next = load_count + USER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select <= KIND_SINE;
      amp_level   <= AMP_MAX;
      phase_step  <= STEP_MIN;
      phase_index <= '0;
      load_count  <= '0;
      stage.valid <= 1'b0;
      for (int i = 0; i < USER_POINTS; i++) user_points[i] <= 8'd0;
    end else begin
      wave_select <= wave_select_next;
      amp_level   <= amp_level_next;
      phase_step  <= phase_step_next;
      phase_index <= phase_index_next;
      load_count  <= load_count_next;
      if (user_wr) user_points[load_count] <= item.rx_byte;
      if (s1_free) stage.valid <= item_take && is_tick;
    end
    if (s1_free) begin
      stage.sample <= sample;
      stage.amp    <= amp_level;
      stage.kind   <= wave_select;
    end
  end

endmodule

FILE: rtl/core/twg_scale.sv
// twg_scale: amplitude scaling (sample * amp / 255) and the result register.
// Depends on twg_pkg.
`timescale 1ns / 1ps

module twg_scale (
  input  logic                clk,
  input  logic                rst,
  input  twg_pkg::twg_stage_t stage,
  output logic                s2_free,
  output logic                out_valid,
  input  logic                out_ready,
  output twg_pkg::twg_out_t   out_data
);
  import twg_pkg::*;

  logic [15:0] prod;
  logic [16:0] quot_sum;

  assign s2_free = !out_valid || out_ready;

  // x / 255 for x <= 255*255: (x + (x >> 8) + 1) >> 8
  assign prod     = 16'(stage.sample) * 16'(stage.amp);
  assign quot_sum = {1'b0, prod} + 17'(prod[15:8]) + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= stage.valid;
    end
    if (s2_free) begin
      out_data.dac_code       <= quot_sum[15:8];
      out_data.wave_kind      <= stage.kind;
      out_data.amp_above_half <= stage.amp[7];
    end
  end

endmodule

FILE: rtl/core/table_waveform_generator.sv
// table_waveform_generator: top level of the lookup-table waveform generator.
// Depends on twg_pkg, twg_ctrl and twg_scale.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  ------------------------------------
//  in       to block   in_valid / in_ready    in_data: req_type, buttons, rx_byte
//  out      from block out_valid / out_ready  out_data: dac_code, wave_kind,
//                                             amp_above_half
//
//  One transaction per cycle on the input, sustained while no output stall
//  holds back a tick. A tick's result passes the lookup register (phase table
//  read), then the result register (8x8 multiply and divide by 255).
//  Button and serial-byte transactions update state as they leave the input
//  register and give no result; an output stall backs up through ticks only.
//  rst is synchronous: sine wave, amplitude 255, step 1, phase 0, user points 0.

module table_waveform_generator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  twg_pkg::twg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output twg_pkg::twg_out_t out_data
);
  import twg_pkg::*;

  // input register
  logic       in_valid_q;
  twg_in_t    in_q;

  logic       item_take;
  logic       s2_free;
  twg_stage_t stage;

  // Free when empty or when the held transaction leaves this cycle
  assign in_ready = !in_valid_q || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  twg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(in_valid_q),
    .item      (in_q),
    .s2_free   (s2_free),
    .item_take (item_take),
    .stage     (stage)
  );

  twg_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .s2_free  (s2_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Non-tick transactions are consumed at once, whatever the output does
  a_ctrl_never_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && in_q.req_type != REQ_TICK |-> item_take)
    else $error("control transaction held in input register");

  // A consumed tick reaches the lookup register on the next cycle
  a_tick_to_stage: assert property (@(posedge clk) disable iff (rst)
    item_take && in_q.req_type == REQ_TICK |=> stage.valid)
    else $error("tick lost between input and lookup register");

  // A stalled lookup register holds its sample
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage.valid && !s2_free |=> stage.valid && $stable(stage))
    else $error("lookup register changed while stalled");

endmodule
